// ===== design/rsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the ray/sphere closest hit core.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int COORD_W     = 32;
   localparam int DL_W        = COORD_W + 1;
   localparam int DIR_W       = 32;
   localparam int DMAG_W      = 31;
   localparam int RAD_W       = 31;
   localparam int B_W         = 35;
   localparam int BMAG_W      = 34;
   localparam int ACC_W       = 72;
   localparam int OPA_W       = 35;
   localparam int OPB_W       = 36;
   localparam int HALF_W      = 18;
   localparam int PROD_W      = OPA_W + HALF_W;
   localparam int DISC_W      = 70;
   localparam int ROOT_W      = 35;
   localparam int REM_W       = 38;
   localparam int STEP_W      = 6;
   localparam int T_W         = 37;
   localparam int DIST_W      = 32;
   localparam int IN_TDATA_W  = 128;
   localparam int OUT_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [STEP_W-1:0] DOT_LAST  = 6'd5;
   localparam logic [STEP_W-1:0] QUAD_LAST = 6'd9;
   localparam logic [STEP_W-1:0] SQRT_LAST = 6'd34;

   localparam logic signed [DIR_W-1:0] DIR_ONE     = 32'sh4000_0000;
   localparam logic signed [DIR_W-1:0] DIR_NEG_ONE = -32'sh4000_0000;
   localparam logic [DIST_W-1:0]       DIST_NONE   = '1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_QUAD,
      ST_SQRT,
      ST_ROOT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic signed [DL_W-1:0] dl_x;
      logic signed [DL_W-1:0] dl_y;
      logic signed [DL_W-1:0] dl_z;
      logic [RAD_W-1:0]       radius;
      logic                   last;
   } sphere_type;

endpackage

// ===== design/rsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_front
// Accepts sphere requests, forms origin minus center and queues the result.
// ----------------------------------------------------------------------------
module rsc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rsc_pkg::IN_TDATA_W-1:0]        req_tdata,  // center_x, center_y, center_z, radius
   input  logic                                  req_tlast,
   input  logic signed [rsc_pkg::COORD_W-1:0]    origin_x,
   input  logic signed [rsc_pkg::COORD_W-1:0]    origin_y,
   input  logic signed [rsc_pkg::COORD_W-1:0]    origin_z,
   output logic                                  q_valid,
   output rsc_pkg::sphere_type                   q_entry,
   input  logic                                  q_pop
);

   rsc_pkg::sphere_type entry_ff [2];
   rsc_pkg::sphere_type push_entry;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   logic signed [rsc_pkg::COORD_W-1:0] cx, cy, cz;

   assign cx = req_tdata[31:0];
   assign cy = req_tdata[63:32];
   assign cz = req_tdata[95:64];

   always_comb begin
      push_entry.dl_x   = {origin_x[31], origin_x} - {cx[31], cx};
      push_entry.dl_y   = {origin_y[31], origin_y} - {cy[31], cy};
      push_entry.dl_z   = {origin_z[31], origin_z} - {cz[31], cz};
      push_entry.radius = req_tdata[126:96];
      push_entry.last   = req_tlast;
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_entry    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== design/rsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_back
// Sequencer: dot product and quadratic terms on one shared multiplier, bit
// serial square root, root selection and the result register.
// ----------------------------------------------------------------------------
module rsc_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [rsc_pkg::DIR_W-1:0]     dir_x,
   input  logic signed [rsc_pkg::DIR_W-1:0]     dir_y,
   input  logic signed [rsc_pkg::DIR_W-1:0]     dir_z,
   input  logic                                 q_valid,
   input  rsc_pkg::sphere_type                  q_entry,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rsc_pkg::OUT_TDATA_W-1:0]      rsp_tdata  // hit, closest_t
);

   rsc_pkg::state_type state_ff, state_in;
   logic [rsc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic signed [rsc_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [rsc_pkg::B_W-1:0]   b_ff, b_in;
   logic [rsc_pkg::DISC_W-1:0]       rad_ff, rad_in;
   logic [rsc_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [rsc_pkg::ROOT_W-1:0]       root_ff, root_in;
   rsc_pkg::sphere_type              ent_ff, ent_in;
   logic                             found_ff, found_in;
   logic [rsc_pkg::DIST_W-1:0]       best_ff, best_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rsc_pkg::OUT_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [rsc_pkg::DL_W-1:0]   mdl_x, mdl_y, mdl_z;
   logic [rsc_pkg::DMAG_W-1:0] md_x, md_y, md_z;
   logic [rsc_pkg::BMAG_W-1:0] b_mag;
   logic [rsc_pkg::OPA_W-1:0]  op_a;
   logic [rsc_pkg::OPB_W-1:0]  op_b;
   logic                       op_neg;
   logic [rsc_pkg::HALF_W-1:0] op_half;
   logic [rsc_pkg::PROD_W-1:0] prod;
   logic [rsc_pkg::ACC_W-1:0]  term;
   logic signed [rsc_pkg::ACC_W-1:0] acc_next;
   logic [rsc_pkg::REM_W-1:0]  rem_t, trial;
   logic signed [rsc_pkg::T_W-1:0] neg_b, t0, t1;
   logic                       pos0, pos1;
   logic [rsc_pkg::DIST_W-1:0] v0, v1, best_mid;
   logic                       found_mid;
   logic signed [rsc_pkg::B_W-1:0] b_next;

   always_comb begin
      mdl_x = ent_ff.dl_x[32] ? -ent_ff.dl_x : ent_ff.dl_x;
      mdl_y = ent_ff.dl_y[32] ? -ent_ff.dl_y : ent_ff.dl_y;
      mdl_z = ent_ff.dl_z[32] ? -ent_ff.dl_z : ent_ff.dl_z;
      md_x  = dir_x[31] ? rsc_pkg::DMAG_W'(-dir_x) : dir_x[30:0];
      md_y  = dir_y[31] ? rsc_pkg::DMAG_W'(-dir_y) : dir_y[30:0];
      md_z  = dir_z[31] ? rsc_pkg::DMAG_W'(-dir_z) : dir_z[30:0];
      b_mag = b_ff[34] ? rsc_pkg::BMAG_W'(-b_ff) : b_ff[33:0];
   end

   // operand selection for the shared multiplier
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      if (state_ff == rsc_pkg::ST_DOT) begin
         unique case (step_ff[3:1])
            3'd0: begin
               op_a   = {4'b0, md_x};
               op_b   = {3'b0, mdl_x};
               op_neg = dir_x[31] ^ ent_ff.dl_x[32];
            end
            3'd1: begin
               op_a   = {4'b0, md_y};
               op_b   = {3'b0, mdl_y};
               op_neg = dir_y[31] ^ ent_ff.dl_y[32];
            end
            3'd2: begin
               op_a   = {4'b0, md_z};
               op_b   = {3'b0, mdl_z};
               op_neg = dir_z[31] ^ ent_ff.dl_z[32];
            end
            default: begin
               op_a   = '0;
               op_b   = '0;
               op_neg = 1'b0;
            end
         endcase
      end else begin
         unique case (step_ff[3:1])
            3'd0: begin
               op_a = {1'b0, b_mag};
               op_b = {2'b0, b_mag};
            end
            3'd1: begin
               op_a = {4'b0, ent_ff.radius};
               op_b = {5'b0, ent_ff.radius};
            end
            3'd2: begin
               op_a   = {2'b0, mdl_x};
               op_b   = {3'b0, mdl_x};
               op_neg = 1'b1;
            end
            3'd3: begin
               op_a   = {2'b0, mdl_y};
               op_b   = {3'b0, mdl_y};
               op_neg = 1'b1;
            end
            3'd4: begin
               op_a   = {2'b0, mdl_z};
               op_b   = {3'b0, mdl_z};
               op_neg = 1'b1;
            end
            default: begin
               op_a   = '0;
               op_b   = '0;
               op_neg = 1'b0;
            end
         endcase
      end
      op_half  = step_ff[0] ? op_b[35:18] : op_b[17:0];
      prod     = op_a * op_half;
      term     = rsc_pkg::ACC_W'(prod) << (step_ff[0] ? rsc_pkg::HALF_W : 0);
      acc_next = op_neg ? acc_ff - $signed(term) : acc_ff + $signed(term);
      b_next   = acc_next[64:30];
   end

   // square root step and root candidates
   always_comb begin
      rem_t = {rem_ff[35:0], rad_ff[69:68]};
      trial = {1'b0, root_ff, 2'b01};
      neg_b = -{{2{b_ff[34]}}, b_ff};
      t0    = neg_b - $signed({2'b0, root_ff});
      t1    = neg_b + $signed({2'b0, root_ff});
      pos0  = !t0[36] && (t0 != '0);
      pos1  = !t1[36] && (t1 != '0);
      v0    = (t0[36:32] != '0) ? rsc_pkg::DIST_NONE : t0[31:0];
      v1    = (t1[36:32] != '0) ? rsc_pkg::DIST_NONE : t1[31:0];
      best_mid  = (pos0 && (!found_ff || v0 < best_ff)) ? v0 : best_ff;
      found_mid = found_ff || pos0;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      ent_in       = ent_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         rsc_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ent_in   = q_entry;
               acc_in   = '0;
               step_in  = '0;
               state_in = rsc_pkg::ST_DOT;
            end
         end
         rsc_pkg::ST_DOT: begin
            acc_in  = acc_next;
            step_in = step_ff + rsc_pkg::STEP_W'(1);
            if (step_ff == rsc_pkg::DOT_LAST) begin
               b_in     = b_next;
               acc_in   = '0;
               step_in  = '0;
               state_in = rsc_pkg::ST_QUAD;
            end
         end
         rsc_pkg::ST_QUAD: begin
            acc_in  = acc_next;
            step_in = step_ff + rsc_pkg::STEP_W'(1);
            if (step_ff == rsc_pkg::QUAD_LAST) begin
               rad_in  = acc_next[69:0];
               rem_in  = '0;
               root_in = '0;
               step_in = '0;
               state_in = acc_next[71] ? rsc_pkg::ST_FIN : rsc_pkg::ST_SQRT;
            end
         end
         rsc_pkg::ST_SQRT: begin
            rad_in  = rad_ff << 2;
            step_in = step_ff + rsc_pkg::STEP_W'(1);
            if (rem_t >= trial) begin
               rem_in  = rem_t - trial;
               root_in = {root_ff[33:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_ff[33:0], 1'b0};
            end
            if (step_ff == rsc_pkg::SQRT_LAST) begin
               state_in = rsc_pkg::ST_ROOT;
            end
         end
         rsc_pkg::ST_ROOT: begin
            best_in  = (pos1 && (!found_mid || v1 < best_mid)) ? v1 : best_mid;
            found_in = found_mid || pos1;
            state_in = rsc_pkg::ST_FIN;
         end
         rsc_pkg::ST_FIN: begin
            if (!ent_ff.last) begin
               state_in = rsc_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, (found_ff ? best_ff : rsc_pkg::DIST_NONE), found_ff};
               found_in     = 1'b0;
               best_in      = rsc_pkg::DIST_NONE;
               state_in     = rsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsc_pkg::ST_IDLE;
         found_ff     <= 1'b0;
         best_ff      <= rsc_pkg::DIST_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      b_ff        <= b_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      ent_ff      <= ent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/ray_sphere_closest_hit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_core
// Closest positive ray/sphere hit over a run of spheres, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Program the ray (origin Q16.16, unit direction Q1.30, clamped to +-1) while
// idle, then stream spheres; tlast closes a run and yields one response with
// the hit flag and closest distance (all ones on a miss). A two-entry queue
// decouples request intake from the solver. The solver handles one sphere at
// a time on a single shared 35x18 multiplier. Most of the time per sphere goes
// to the 35-step bit-serial square root, which is skipped when the
// discriminant is negative.
module ray_sphere_closest_hit_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rsc_pkg::IN_TDATA_W-1:0]      req_tdata,  // center_x, center_y, center_z, radius
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rsc_pkg::OUT_TDATA_W-1:0]     rsp_tdata,  // hit, closest_t
   input  logic                                csr_we,
   input  logic [rsc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [rsc_pkg::COORD_W-1:0]         csr_wdata
);

   logic signed [rsc_pkg::COORD_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [rsc_pkg::DIR_W-1:0]   dir_x_ff, dir_y_ff, dir_z_ff;
   logic signed [rsc_pkg::DIR_W-1:0]   dir_in;
   logic                               q_valid;
   logic                               q_pop;
   rsc_pkg::sphere_type                q_entry;

   always_comb begin
      if ($signed(csr_wdata) > rsc_pkg::DIR_ONE) begin
         dir_in = rsc_pkg::DIR_ONE;
      end else if ($signed(csr_wdata) < rsc_pkg::DIR_NEG_ONE) begin
         dir_in = rsc_pkg::DIR_NEG_ONE;
      end else begin
         dir_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         dir_x_ff    <= rsc_pkg::DIR_ONE;
         dir_y_ff    <= '0;
         dir_z_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            rsc_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            rsc_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            rsc_pkg::CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            rsc_pkg::CSR_DIR_X:    dir_x_ff    <= dir_in;
            rsc_pkg::CSR_DIR_Y:    dir_y_ff    <= dir_in;
            rsc_pkg::CSR_DIR_Z:    dir_z_ff    <= dir_in;
            default: begin
            end
         endcase
      end
   end

   rsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .origin_z   (origin_z_ff),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   rsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .dir_x      (dir_x_ff),
      .dir_y      (dir_y_ff),
      .dir_z      (dir_z_ff),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_miss_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == rsc_pkg::DIST_NONE)
      else $error("miss response without all-ones distance");
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[32:1] != '0)
      else $error("hit response with zero distance");
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("solver took an entry from an empty queue");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule
